[design/eint_pkg.sv]
// Package for the eased interpolator: request and result item types,
// curve codes and the sine series used to build the cosine table.
// No dependencies.
`timescale 1ns / 1ps

package eint_pkg;

    typedef enum logic [1:0] {
        EASE_LINEAR,
        EASE_IN,
        EASE_OUT,
        EASE_INOUT
    } t_ease;

    typedef struct packed {
        t_ease              func;
        logic [15:0]        elapsed;
        logic [15:0]        duration;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic               bad_duration;
    } t_out_item;

    typedef struct packed {
        t_ease              func;
        logic               bad;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
    } t_job;

    localparam int QUEUE_DEPTH = 4;
    localparam int TIME_FIELD_BITS = 16;

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] Q30_HALF = 64'd1 << 29;

    typedef logic [63:0] t_div_list [1:6];
    localparam t_div_list SIN_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    function automatic logic [63:0] sin_q30(input logic [63:0] y);
        logic [63:0] y2;
        logic [63:0] term;
        logic [63:0] sum;
        y2   = (y * y + Q30_HALF) >> 30;
        term = y;
        sum  = y;
        for (int k = 1; k <= 6; k++) begin
            term = ((term * y2 + Q30_HALF) >> 30) / SIN_DIV[k];
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

endpackage

[design/eint_front.sv]
// Front part: accepts requests, flags zero duration and forms progress
// with a restoring divider, one quotient bit per stage. Uses eint_pkg.
`timescale 1ns / 1ps

module eint_front #(
    parameter int TW = 16,
    parameter int F  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  eint_pkg::t_in_item i_item,
    input  logic               i_full,
    output logic               o_push,
    output eint_pkg::t_job     o_job,
    output logic [F:0]         o_p
);

    logic            r_vld [0:F];
    logic [TW-1:0]   r_rem [0:F];
    logic [TW-1:0]   r_div [0:F];
    logic [F-1:0]    r_quo [0:F];
    logic            r_sat [0:F];
    eint_pkg::t_job  r_job [0:F];

    logic            fe;
    logic [TW-1:0]   el;
    logic [TW-1:0]   du;
    eint_pkg::t_job  n_job;

    assign fe      = !(r_vld[F] && i_full);
    assign o_stall = !fe;
    assign o_push  = r_vld[F] && !i_full;
    assign o_job   = r_job[F];
    assign o_p     = r_sat[F] ? {1'b1, {F{1'b0}}} : {1'b0, r_quo[F]};

    assign el = i_item.elapsed[TW-1:0];
    assign du = i_item.duration[TW-1:0];

    always_comb begin
        n_job.func    = i_item.func;
        n_job.bad     = (du == '0);
        n_job.start_x = i_item.start_x;
        n_job.start_y = i_item.start_y;
        n_job.start_z = i_item.start_z;
        n_job.end_x   = i_item.end_x;
        n_job.end_y   = i_item.end_y;
        n_job.end_z   = i_item.end_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (fe) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_rem[0] <= (el >= du) ? '0 : el;
            r_div[0] <= du;
            r_quo[0] <= '0;
            r_sat[0] <= (el >= du);
            r_job[0] <= n_job;
        end
    end

    for (genvar gs = 0; gs < F; gs++) begin : g_stage
        logic [TW:0] sh;
        logic        ge;
        logic [TW:0] n_rem;

        assign sh    = {r_rem[gs], 1'b0};
        assign ge    = (sh >= {1'b0, r_div[gs]});
        assign n_rem = ge ? (sh - {1'b0, r_div[gs]}) : sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gs+1] <= 1'b0;
            end else if (fe) begin
                r_vld[gs+1] <= r_vld[gs];
            end
        end

        always_ff @(posedge i_clk) begin
            if (fe) begin
                r_rem[gs+1] <= n_rem[TW-1:0];
                r_div[gs+1] <= r_div[gs];
                r_quo[gs+1] <= {r_quo[gs][F-2:0], ge};
                r_sat[gs+1] <= r_sat[gs];
                r_job[gs+1] <= r_job[gs];
            end
        end
    end

endmodule

[design/eint_fifo.sv]
// Short request queue between the front and back parts.
// Uses eint_pkg for its depth.
`timescale 1ns / 1ps

module eint_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_avail,
    output logic [W-1:0] o_data
);

    localparam int DEPTH = eint_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail) else $error("pop from empty queue");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count did not advance");
`endif

endmodule

[design/eint_back.sv]
// Back part: shapes progress by the selected curve (cosine table for the
// ease-in-out curve) and blends the three components. Uses eint_pkg.
`timescale 1ns / 1ps

module eint_back #(
    parameter int F = 16,
    parameter int D = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    input  eint_pkg::t_job      i_job,
    input  logic [F:0]          i_p,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output eint_pkg::t_out_item o_item
);

    localparam int P   = F + 1;
    localparam int DW  = $clog2(D + 1);
    localparam int OW  = (P > DW) ? P : DW;
    localparam int M1W = P + OW;
    localparam int IW  = M1W - F;
    localparam int PW  = 33 + P;
    localparam int VW  = PW + 1;
    localparam int RW  = VW - F;
    localparam logic [P-1:0] ONE  = {1'b1, {F{1'b0}}};
    localparam logic [63:0]  ONE64 = 64'd1 << F;

    logic [P-1:0] rom [0:D];

    for (genvar gi = 0; gi <= D; gi++) begin : g_rom
        localparam logic [63:0] J  = (gi <= D / 2) ? 64'(gi) : 64'(D - gi);
        localparam logic [63:0] Y  = (eint_pkg::PI_Q30 * J + 64'(D)) / (64'(2 * D));
        localparam logic [63:0] S  = eint_pkg::sin_q30(Y);
        localparam logic [63:0] E  = (S * S + (64'd1 << (59 - F))) >> (60 - F);
        localparam logic [63:0] V  = (gi <= D / 2) ? E : (ONE64 - E);
        assign rom[gi] = V[P-1:0];
    end

    logic                be;
    logic                r_v [0:5];
    eint_pkg::t_job      r_job [0:4];

    logic [M1W-1:0]      r_m1;
    logic [P-1:0]        r_p0;
    logic [P-1:0]        r_base1;
    logic [P-1:0]        r_x1;
    logic [P-1:0]        r_y1;
    logic                r_neg1;
    logic                r_dir1;
    logic [2*P-1:0]      r_m2;
    logic [P-1:0]        r_base2;
    logic                r_neg2;
    logic                r_dir2;
    logic [P-1:0]        r_e;
    logic [P-1:0]        r_we;
    logic signed [PW-1:0] r_ps [0:2];
    logic signed [PW-1:0] r_pt [0:2];
    eint_pkg::t_out_item r_out;

    assign be      = !(r_v[5] && i_stall);
    assign o_pop   = be && i_avail;
    assign o_valid = r_v[5];
    assign o_item  = r_out;

    logic [P-1:0]   q0;
    logic [OW-1:0]  ma;
    logic [OW-1:0]  mb;

    always_comb begin
        q0 = ONE - i_p;
        ma = OW'(i_p);
        mb = OW'(D);
        unique case (i_job.func)
            eint_pkg::EASE_LINEAR: begin
                ma = OW'(i_p);
                mb = OW'(D);
            end
            eint_pkg::EASE_IN: begin
                ma = OW'(i_p);
                mb = OW'(i_p);
            end
            eint_pkg::EASE_OUT: begin
                ma = OW'(q0);
                mb = OW'(q0);
            end
            eint_pkg::EASE_INOUT: begin
                ma = OW'(i_p);
                mb = OW'(D);
            end
            default: begin
                ma = OW'(i_p);
                mb = OW'(D);
            end
        endcase
    end

    logic [M1W-1:0] rnd1_w;
    logic [P-1:0]   rnd1;
    logic [IW-1:0]  idx;
    logic           at_end;
    logic [DW-1:0]  ia;
    logic [DW-1:0]  ib;
    logic [P-1:0]   ra;
    logic [P-1:0]   rb;
    logic [P-1:0]   q1;
    logic [P-1:0]   n_base1;
    logic [P-1:0]   n_x1;
    logic [P-1:0]   n_y1;
    logic           n_neg1;
    logic           n_dir1;

    always_comb begin
        rnd1_w = r_m1 + M1W'(ONE >> 1);
        rnd1   = rnd1_w[F+P-1:F];
        idx    = r_m1[M1W-1:F];
        at_end = (idx >= IW'(D));
        ia     = at_end ? DW'(D) : idx[DW-1:0];
        ib     = at_end ? DW'(D) : (idx[DW-1:0] + 1'b1);
        ra     = rom[ia];
        rb     = rom[ib];
        q1     = ONE - r_p0;
        n_base1 = r_p0;
        n_x1    = '0;
        n_y1    = '0;
        n_neg1  = 1'b0;
        n_dir1  = 1'b1;
        unique case (r_job[0].func)
            eint_pkg::EASE_LINEAR: begin
                n_base1 = r_p0;
            end
            eint_pkg::EASE_IN: begin
                n_base1 = rnd1;
            end
            eint_pkg::EASE_OUT: begin
                n_base1 = ONE;
                n_x1    = rnd1;
                n_y1    = q1;
                n_neg1  = 1'b1;
                n_dir1  = 1'b0;
            end
            eint_pkg::EASE_INOUT: begin
                n_base1 = ra;
                n_x1    = (ra > rb) ? (ra - rb) : (rb - ra);
                n_y1    = {1'b0, r_m1[F-1:0]};
                n_neg1  = (ra > rb);
                n_dir1  = 1'b0;
            end
            default: begin
                n_base1 = r_p0;
            end
        endcase
    end

    logic [2*P-1:0] rnd2_w;
    logic [P:0]     rnd2;
    logic [P:0]     e_w;
    logic [P-1:0]   n_e;

    always_comb begin
        rnd2_w = r_m2 + (2*P)'(ONE >> 1);
        rnd2   = rnd2_w[F+P:F];
        if (r_dir2) begin
            e_w = {1'b0, r_base2};
        end else if (r_neg2) begin
            e_w = {1'b0, r_base2} - rnd2;
        end else begin
            e_w = {1'b0, r_base2} + rnd2;
        end
        n_e = (e_w > {1'b0, ONE}) ? ONE : e_w[P-1:0];
    end

    logic signed [31:0] sc [0:2];
    logic signed [31:0] tc [0:2];
    logic signed [31:0] oc [0:2];

    always_comb begin
        sc[0] = r_job[4].start_x;
        sc[1] = r_job[4].start_y;
        sc[2] = r_job[4].start_z;
        tc[0] = r_job[3].end_x;
        tc[1] = r_job[3].end_y;
        tc[2] = r_job[3].end_z;
    end

    logic signed [31:0] s3 [0:2];

    always_comb begin
        s3[0] = r_job[3].start_x;
        s3[1] = r_job[3].start_y;
        s3[2] = r_job[3].start_z;
    end

    for (genvar gc = 0; gc < 3; gc++) begin : g_comp
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] vr;
        logic signed [RW-1:0] r;

        assign v  = VW'(r_ps[gc]) + VW'(r_pt[gc]);
        assign vr = (v + VW'(ONE >> 1)) >>> F;
        assign r  = vr[RW-1:0];

        always_comb begin
            if (r_job[4].bad) begin
                oc[gc] = sc[gc];
            end else if (r > RW'(33'sh0_7FFF_FFFF)) begin
                oc[gc] = 32'sh7FFF_FFFF;
            end else if (r < -RW'(33'sh0_8000_0000)) begin
                oc[gc] = -32'sh8000_0000;
            end else begin
                oc[gc] = r[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (be) begin
                r_ps[gc] <= PW'(s3[gc] * $signed({1'b0, r_we}));
                r_pt[gc] <= PW'(tc[gc] * $signed({1'b0, r_e}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (be) begin
            r_v[0] <= i_avail;
            for (int k = 1; k < 6; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            r_job[0] <= i_job;
            for (int k = 1; k < 5; k++) begin
                r_job[k] <= r_job[k-1];
            end
            r_m1    <= M1W'(ma) * M1W'(mb);
            r_p0    <= i_p;
            r_base1 <= n_base1;
            r_x1    <= n_x1;
            r_y1    <= n_y1;
            r_neg1  <= n_neg1;
            r_dir1  <= n_dir1;
            r_m2    <= (2*P)'(r_x1) * (2*P)'(r_y1);
            r_base2 <= r_base1;
            r_neg2  <= r_neg1;
            r_dir2  <= r_dir1;
            r_e     <= n_e;
            r_we    <= ONE - n_e;
            r_out.value_x      <= oc[0];
            r_out.value_y      <= oc[1];
            r_out.value_z      <= oc[2];
            r_out.bad_duration <= r_job[4].bad;
        end
    end

endmodule

[design/eased_interpolator.sv]
// Top level of the eased interpolator: front divider, request queue and
// curve/blend back part. Uses eint_pkg, eint_front, eint_fifo, eint_back.
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_stall   i_item (t_in_item)
//   result    out        o_valid / i_stall   o_item (t_out_item)
//
// One request per cycle while the result side does not stall; one result per request.
// A request passes through the divider stages, the queue and the curve and
// blend stages, in that order.
// Reset clears all valid bits and the queue pointers; payload is not reset.
// A stall on the result side fills the queue, then stalls the requests.
`timescale 1ns / 1ps

module eased_interpolator #(
    parameter int TIME_BITS       = 16,
    parameter int FRAC_BITS       = 16,
    parameter int COS_TABLE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  eint_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output eint_pkg::t_out_item o_item
);

    localparam int TW = (TIME_BITS < eint_pkg::TIME_FIELD_BITS) ?
                        TIME_BITS : eint_pkg::TIME_FIELD_BITS;
    localparam int P  = FRAC_BITS + 1;
    localparam int JW = P + $bits(eint_pkg::t_job);

    logic                push;
    logic                full;
    logic                pop;
    logic                avail;
    eint_pkg::t_job      f_job;
    logic [P-1:0]        f_p;
    logic [JW-1:0]       q_data;
    eint_pkg::t_job      b_job;
    logic [P-1:0]        b_p;

    eint_front #(
        .TW (TW),
        .F  (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_job   (f_job),
        .o_p     (f_p)
    );

    eint_fifo #(
        .W (JW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_p, f_job}),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_data  (q_data)
    );

    assign b_p   = q_data[JW-1:JW-P];
    assign b_job = q_data[JW-P-1:0];

    eint_back #(
        .F (FRAC_BITS),
        .D (COS_TABLE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_job   (b_job),
        .i_p     (b_p),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

[dv/tb_eased_interpolator.sv]
// Self-checking bench for eased_interpolator: random and directed requests,
// each predicted in-bench and checked against the result stream in order.
// Depends on eint_pkg and the eased_interpolator RTL.
`timescale 1ns / 1ps

module tb_eased_interpolator;

    localparam int FB = 16;
    localparam int DEPTH = 256;
    localparam logic [63:0] ONE = 64'd1 << FB;
    localparam logic [63:0] HALF = 64'd1 << (FB - 1);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    eint_pkg::t_in_item i_item = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    eint_pkg::t_out_item o_item;

    eased_interpolator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    eint_pkg::t_in_item pending_reqs[$];
    eint_pkg::t_out_item expected_vals[$];
    logic [63:0] cos_rom [0:DEPTH];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int mismatches = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] series_sin(input logic [63:0] y);
        logic [63:0] y2;
        logic [63:0] term;
        logic [63:0] sum;
        y2 = (y * y + (64'd1 << 29)) >> 30;
        term = y;
        sum = y;
        for (int k = 1; k <= 6; k++) begin
            term = ((term * y2 + (64'd1 << 29)) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] eased_weight(input eint_pkg::t_ease fn,
                                                 input logic [63:0] p);
        logic [63:0] q;
        logic [63:0] q2;
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] fr;
        logic [63:0] a;
        logic [63:0] b;
        case (fn)
            eint_pkg::EASE_LINEAR: begin
                return p;
            end
            eint_pkg::EASE_IN: begin
                return (p * p + HALF) >> FB;
            end
            eint_pkg::EASE_OUT: begin
                q = ONE - p;
                q2 = (q * q + HALF) >> FB;
                return ONE - ((q2 * q + HALF) >> FB);
            end
            default: begin
                pos = p * DEPTH;
                idx = pos >> FB;
                fr = pos & (ONE - 1);
                if (idx >= DEPTH) return cos_rom[DEPTH];
                a = cos_rom[idx];
                b = cos_rom[idx + 1];
                if (b >= a) return a + (((b - a) * fr + HALF) >> FB);
                return a - (((a - b) * fr + HALF) >> FB);
            end
        endcase
    endfunction

    function automatic logic signed [31:0] blend_component(input logic signed [31:0] s,
                                                           input logic signed [31:0] t,
                                                           input logic [63:0] e);
        logic signed [63:0] v;
        logic signed [63:0] r;
        v = 64'(s) * $signed(ONE - e) + 64'(t) * $signed(e);
        r = (v + $signed(HALF)) >>> FB;
        if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
        if (r < -64'sh80000000) r = -64'sh80000000;
        return r[31:0];
    endfunction

    function automatic eint_pkg::t_out_item predict_interp(input eint_pkg::t_in_item it);
        eint_pkg::t_out_item o;
        logic [63:0] p;
        logic [63:0] e;
        if (it.duration == 0) begin
            o.value_x = it.start_x;
            o.value_y = it.start_y;
            o.value_z = it.start_z;
            o.bad_duration = 1'b1;
            return o;
        end
        p = (64'(it.elapsed) << FB) / it.duration;
        if (p > ONE) p = ONE;
        e = eased_weight(it.func, p);
        if (e > ONE) e = ONE;
        o.value_x = blend_component(it.start_x, it.end_x, e);
        o.value_y = blend_component(it.start_y, it.end_y, e);
        o.value_z = blend_component(it.start_z, it.end_z, e);
        o.bad_duration = 1'b0;
        return o;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h3FFFF) - 32'h1FFFF);
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic eint_pkg::t_in_item rand_request();
        eint_pkg::t_in_item it;
        it.func = eint_pkg::t_ease'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0: it.duration = 16'd0;
            1: it.duration = 16'hFFFF;
            2: it.duration = 16'($urandom_range(1, 16));
            default: it.duration = 16'($urandom());
        endcase
        case ($urandom_range(0, 9))
            0: it.elapsed = 16'($urandom());
            1: it.elapsed = it.duration + 16'($urandom_range(0, 9));
            default: it.elapsed = (it.duration == 0) ? 16'($urandom())
                                  : 16'($urandom_range(0, it.duration));
        endcase
        it.start_x = rand_coord();
        it.start_y = rand_coord();
        it.start_z = rand_coord();
        it.end_x = rand_coord();
        it.end_y = rand_coord();
        it.end_z = rand_coord();
        return it;
    endfunction

    function automatic eint_pkg::t_in_item make_request(input eint_pkg::t_ease fn,
                                                        input logic [15:0] el,
                                                        input logic [15:0] du,
                                                        input logic signed [31:0] s,
                                                        input logic signed [31:0] t);
        eint_pkg::t_in_item it;
        it.func = fn;
        it.elapsed = el;
        it.duration = du;
        it.start_x = s;
        it.start_y = -s;
        it.start_z = 32'sd0;
        it.end_x = t;
        it.end_y = ~t;
        it.end_z = 32'sh7FFFFFFF;
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_item <= pending_reqs.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_valid && !o_stall && i_rst_n) begin
            expected_vals.push_back(predict_interp(i_item));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        eint_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_vals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_item);
            end else begin
                want = expected_vals.pop_front();
                if (o_item.value_x !== want.value_x || o_item.value_y !== want.value_y ||
                    o_item.value_z !== want.value_z ||
                    o_item.bad_duration !== want.bad_duration) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("expected %h actual %h", want, o_item);
                    end
                end
            end
        end
    end

    task automatic drain_all();
        while (pending_reqs.size() > 0 || i_valid || expected_vals.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [63:0] y;
        logic [63:0] s;
        for (int i = 0; i <= DEPTH / 2; i++) begin
            y = (64'd3373259426 * i + DEPTH) / (2 * DEPTH);
            s = series_sin(y);
            cos_rom[i] = (s * s + (64'd1 << (59 - FB))) >> (60 - FB);
        end
        for (int i = DEPTH / 2 + 1; i <= DEPTH; i++) cos_rom[i] = ONE - cos_rom[DEPTH - i];

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int f = 0; f < 4; f++) begin
            pending_reqs.push_back(make_request(eint_pkg::t_ease'(f), 16'd0, 16'd100,
                                                32'sh7FFFFFFF, 32'sh80000000));
            pending_reqs.push_back(make_request(eint_pkg::t_ease'(f), 16'd50, 16'd100,
                                                32'sh80000000, 32'sh7FFFFFFF));
            pending_reqs.push_back(make_request(eint_pkg::t_ease'(f), 16'hFFFF, 16'd1,
                                                32'sh10000, -32'sh10000));
            pending_reqs.push_back(make_request(eint_pkg::t_ease'(f), 16'hFFFF, 16'd0,
                                                32'shFFFFFFFF, 32'sd5));
            pending_reqs.push_back(make_request(eint_pkg::t_ease'(f), 16'h7FFF, 16'hFFFF,
                                                32'sh12345678, 32'shEDCBA987));
        end
        drain_all();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 58 : (ph == 3 ? 11 : 0);
            recv_stall_pct = (ph == 2) ? 58 : (ph == 3 ? 11 : 0);
            if (ph == 1) hold_cycles = 300;
            for (int n = 0; n < 250; n++) pending_reqs.push_back(rand_request());
            drain_all();
        end
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("eased_interpolator: match");
        end else begin
            $display("eased_interpolator: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("eased_interpolator: mismatch");
        $finish;
    end
endmodule
